// File: rtl/clcd_pkg.sv
// Package: types, constants and microcode table for the character LCD sequencer.
`default_nettype none
package clcd_pkg;

    localparam int UPC_W = 6;

    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_HOME    = 8'h02;
    localparam logic [7:0] CMD_DDRAM   = 8'h80;
    localparam logic [7:0] ROW1_BASE   = 8'h40;
    localparam logic [7:0] INIT_BYTE   = 8'h33;
    localparam logic [5:0] POWER_WAIT  = 6'd40;

    localparam logic [7:0] FSET_RST    = 8'h28;
    localparam logic [7:0] DCTL_RST    = 8'h0F;
    localparam logic [7:0] EMODE_RST   = 8'h06;

    localparam logic [UPC_W-1:0] UA_BYTE = 6'd0;
    localparam logic [UPC_W-1:0] UA_INIT = 6'd5;

    typedef enum logic [2:0] {
        OP_CMD   = 3'd0,
        OP_CHAR  = 3'd1,
        OP_POS   = 3'd2,
        OP_CLEAR = 3'd3,
        OP_INIT  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        CFG_FSET  = 2'd0,
        CFG_DCTL  = 2'd1,
        CFG_EMODE = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SRC_REQ   = 3'd0,
        SRC_INIT  = 3'd1,
        SRC_FSET  = 3'd2,
        SRC_DCTL  = 3'd3,
        SRC_CLEAR = 3'd4,
        SRC_EMODE = 3'd5,
        SRC_HOME  = 3'd6
    } t_src;

    typedef enum logic [1:0] {
        SET_0    = 2'd0,
        SET_1    = 2'd1,
        SET_TAIL = 2'd2
    } t_settle;

    // one microcode word
    typedef struct packed {
        t_src       src;
        logic       lo_nib;
        logic       en;
        t_settle    settle;
        logic       wait_tail;
        logic [5:0] wait_ms;
        logic       last;
    } t_ucw;

    // request decode handed to the sequencer
    typedef struct packed {
        logic go;
        logic init;
    } t_disp;

    function automatic t_ucw mk(t_src s, logic lo, logic en, t_settle st,
                                logic wt, logic [5:0] w, logic l);
        t_ucw u;
        u.src       = s;
        u.lo_nib    = lo;
        u.en        = en;
        u.settle    = st;
        u.wait_tail = wt;
        u.wait_ms   = w;
        u.last      = l;
        return u;
    endfunction

    // five-step byte transfer inside init, tail waits 2 ms
    function automatic t_ucw bstep(t_src s, logic [2:0] ph, logic l);
        t_ucw u;
        case (ph)
            3'd0:    u = mk(s, 1'b0, 1'b0, SET_1, 1'b0, 6'd0, 1'b0);
            3'd1:    u = mk(s, 1'b0, 1'b1, SET_1, 1'b0, 6'd0, 1'b0);
            3'd2:    u = mk(s, 1'b0, 1'b0, SET_0, 1'b0, 6'd0, 1'b0);
            3'd3:    u = mk(s, 1'b1, 1'b1, SET_1, 1'b0, 6'd0, 1'b0);
            default: u = mk(s, 1'b1, 1'b0, SET_0, 1'b0, 6'd2, l);
        endcase
        return u;
    endfunction

    function automatic t_ucw ucode(logic [UPC_W-1:0] pc);
        t_ucw u;
        case (pc)
            6'd0:  u = mk(SRC_REQ, 1'b0, 1'b0, SET_1, 1'b0, 6'd0, 1'b0);
            6'd1:  u = mk(SRC_REQ, 1'b0, 1'b1, SET_1, 1'b0, 6'd0, 1'b0);
            6'd2:  u = mk(SRC_REQ, 1'b0, 1'b0, SET_0, 1'b0, 6'd0, 1'b0);
            6'd3:  u = mk(SRC_REQ, 1'b1, 1'b1, SET_1, 1'b0, 6'd0, 1'b0);
            6'd4:  u = mk(SRC_REQ, 1'b1, 1'b0, SET_TAIL, 1'b1, 6'd0, 1'b1);
            6'd5:  u = mk(SRC_INIT, 1'b0, 1'b0, SET_0, 1'b0, POWER_WAIT, 1'b0);
            6'd6:  u = mk(SRC_INIT, 1'b0, 1'b0, SET_1, 1'b0, 6'd0, 1'b0);
            6'd7,
            6'd9,
            6'd11: u = mk(SRC_INIT, 1'b0, 1'b1, SET_1, 1'b0, 6'd0, 1'b0);
            6'd8,
            6'd10,
            6'd12: u = mk(SRC_INIT, 1'b0, 1'b0, SET_0, 1'b0, 6'd1, 1'b0);
            6'd13: u = bstep(SRC_FSET, 3'd0, 1'b0);
            6'd14: u = bstep(SRC_FSET, 3'd1, 1'b0);
            6'd15: u = bstep(SRC_FSET, 3'd2, 1'b0);
            6'd16: u = bstep(SRC_FSET, 3'd3, 1'b0);
            6'd17: u = bstep(SRC_FSET, 3'd4, 1'b0);
            6'd18: u = bstep(SRC_DCTL, 3'd0, 1'b0);
            6'd19: u = bstep(SRC_DCTL, 3'd1, 1'b0);
            6'd20: u = bstep(SRC_DCTL, 3'd2, 1'b0);
            6'd21: u = bstep(SRC_DCTL, 3'd3, 1'b0);
            6'd22: u = bstep(SRC_DCTL, 3'd4, 1'b0);
            6'd23: u = bstep(SRC_CLEAR, 3'd0, 1'b0);
            6'd24: u = bstep(SRC_CLEAR, 3'd1, 1'b0);
            6'd25: u = bstep(SRC_CLEAR, 3'd2, 1'b0);
            6'd26: u = bstep(SRC_CLEAR, 3'd3, 1'b0);
            6'd27: u = bstep(SRC_CLEAR, 3'd4, 1'b0);
            6'd28: u = bstep(SRC_EMODE, 3'd0, 1'b0);
            6'd29: u = bstep(SRC_EMODE, 3'd1, 1'b0);
            6'd30: u = bstep(SRC_EMODE, 3'd2, 1'b0);
            6'd31: u = bstep(SRC_EMODE, 3'd3, 1'b0);
            6'd32: u = bstep(SRC_EMODE, 3'd4, 1'b0);
            6'd33: u = bstep(SRC_HOME, 3'd0, 1'b0);
            6'd34: u = bstep(SRC_HOME, 3'd1, 1'b0);
            6'd35: u = bstep(SRC_HOME, 3'd2, 1'b0);
            6'd36: u = bstep(SRC_HOME, 3'd3, 1'b0);
            6'd37: u = bstep(SRC_HOME, 3'd4, 1'b1);
            default: u = mk(SRC_REQ, 1'b0, 1'b0, SET_0, 1'b0, 6'd0, 1'b1);
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// File: rtl/clcd_if.sv
// Interfaces: request, pin update and configuration channels.
`default_nettype none
interface clcd_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] value_byte;
    logic [5:0] column;
    logic [1:0] row;
    modport source (output valid, op, value_byte, column, row, input ready);
    modport sink   (input valid, op, value_byte, column, row, output ready);
endinterface

interface clcd_upd_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       enable_level;
    logic [3:0] bus_nibble;
    logic       settle_short;
    logic [5:0] wait_ms;
    logic       last;
    modport source (output valid, reg_select, enable_level, bus_nibble, settle_short,
                    wait_ms, last, input ready);
    modport sink   (input valid, reg_select, enable_level, bus_nibble, settle_short,
                    wait_ms, last, output ready);
endinterface

interface clcd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/clcd_useq.sv
// Microcode sequencer: step counter, dispatch on request and ROM lookup.
`default_nettype none
module clcd_useq
    import clcd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_req_valid,
    input  wire t_disp i_disp,
    input  wire logic  i_slot,
    output t_ucw       o_uw,
    output logic       o_step,
    output logic       o_req_ready
);

    logic             r_busy, n_busy;
    logic [UPC_W-1:0] r_pc, n_pc;
    logic             req_fire;

    assign o_uw        = ucode(r_pc);
    assign o_step      = r_busy && i_slot;
    assign o_req_ready = !r_busy || (o_step && o_uw.last);
    assign req_fire    = i_req_valid && o_req_ready;

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (o_step) begin
            n_pc = r_pc + 6'd1;
            if (o_uw.last) begin
                n_busy = 1'b0;
            end
        end
        if (req_fire && i_disp.go) begin
            n_busy = 1'b1;
            n_pc   = i_disp.init ? UA_INIT : UA_BYTE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= UA_BYTE;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

endmodule
`default_nettype wire

// File: rtl/clcd_dp.sv
// Datapath: request decode, init command registers and output register.
`default_nettype none
module clcd_dp
    import clcd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_fire,
    input  wire logic [2:0] i_op,
    input  wire logic [7:0] i_value_byte,
    input  wire logic [5:0] i_column,
    input  wire logic [1:0] i_row,
    input  wire logic       i_cfg_fire,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire t_ucw       i_uw,
    input  wire logic       i_step,
    output t_disp           o_disp,
    output logic            o_slot,
    clcd_upd_if.source      o_upd
);

    logic [7:0] r_fset, r_dctl, r_emode;
    logic       r_rs, n_rs;
    logic [7:0] r_byte, n_byte;
    logic       r_tail_settle, n_tail_settle;
    logic [5:0] r_tail_wait, n_tail_wait;
    logic       r_valid;
    logic       r_o_rs, r_o_en, r_o_settle, r_o_last;
    logic [3:0] r_o_nib;
    logic [5:0] r_o_wait;
    logic [7:0] pos_byte;
    logic [7:0] cur_byte;
    logic       cur_settle;

    assign pos_byte = (i_row[0] ? (ROW1_BASE + {2'b00, i_column}) : {2'b00, i_column})
                      | CMD_DDRAM;

    always_comb begin
        o_disp        = '0;
        n_rs          = 1'b0;
        n_byte        = i_value_byte;
        n_tail_settle = 1'b0;
        n_tail_wait   = 6'd0;
        case (t_op'(i_op))
            OP_CMD: begin
                o_disp.go = 1'b1;
            end
            OP_CHAR: begin
                o_disp.go     = (i_value_byte != 8'd0);
                n_rs          = 1'b1;
                n_tail_settle = 1'b1;
            end
            OP_POS: begin
                o_disp.go   = !i_row[1];
                n_byte      = pos_byte;
                n_tail_wait = 6'd1;
            end
            OP_CLEAR: begin
                o_disp.go   = 1'b1;
                n_byte      = CMD_CLEAR;
                n_tail_wait = 6'd2;
            end
            OP_INIT: begin
                o_disp.go   = 1'b1;
                o_disp.init = 1'b1;
            end
            default: begin
                o_disp.go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_req_fire) begin
            r_rs          <= n_rs;
            r_byte        <= n_byte;
            r_tail_settle <= n_tail_settle;
            r_tail_wait   <= n_tail_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fset  <= FSET_RST;
            r_dctl  <= DCTL_RST;
            r_emode <= EMODE_RST;
        end else if (i_cfg_fire) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FSET:  r_fset  <= i_cfg_data;
                CFG_DCTL:  r_dctl  <= i_cfg_data;
                CFG_EMODE: r_emode <= i_cfg_data;
                default:   r_fset  <= r_fset;
            endcase
        end
    end

    always_comb begin
        case (i_uw.src)
            SRC_REQ:   cur_byte = r_byte;
            SRC_INIT:  cur_byte = INIT_BYTE;
            SRC_FSET:  cur_byte = r_fset;
            SRC_DCTL:  cur_byte = r_dctl;
            SRC_CLEAR: cur_byte = CMD_CLEAR;
            SRC_EMODE: cur_byte = r_emode;
            SRC_HOME:  cur_byte = CMD_HOME;
            default:   cur_byte = r_byte;
        endcase
        case (i_uw.settle)
            SET_0:    cur_settle = 1'b0;
            SET_1:    cur_settle = 1'b1;
            SET_TAIL: cur_settle = r_tail_settle;
            default:  cur_settle = 1'b0;
        endcase
    end

    assign o_slot = !r_valid || o_upd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= 1'b1;
        end else if (o_upd.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_o_rs     <= (i_uw.src == SRC_REQ) ? r_rs : 1'b0;
            r_o_en     <= i_uw.en;
            r_o_nib    <= i_uw.lo_nib ? cur_byte[3:0] : cur_byte[7:4];
            r_o_settle <= cur_settle;
            r_o_wait   <= i_uw.wait_tail ? r_tail_wait : i_uw.wait_ms;
            r_o_last   <= i_uw.last;
        end
    end

    assign o_upd.valid        = r_valid;
    assign o_upd.reg_select   = r_o_rs;
    assign o_upd.enable_level = r_o_en;
    assign o_upd.bus_nibble   = r_o_nib;
    assign o_upd.settle_short = r_o_settle;
    assign o_upd.wait_ms      = r_o_wait;
    assign o_upd.last         = r_o_last;

endmodule
`default_nettype wire

// File: rtl/char_lcd_4bit_interface_sequencer.sv
// Top level: character LCD 4-bit bus sequencer.
//
// i_req takes one request (raw command, character, cursor position, clear,
// init). o_upd gives the pin updates it causes, in order, the final one
// flagged by last. A zero character, a row of 2 or 3 and op
// codes 5..7 are accepted and cause no update. i_cfg writes the three init
// command registers; it is always ready and should be used only while idle.
// A byte request gives 5 updates, init gives 33; updates leave the output
// register one per cycle when o_upd.ready stays high. An accepted request
// loads the step counter first; the output register then takes the first
// update. The next request is taken in the cycle the final update is
// loaded, so requests follow with no idle step between. When the receiver
// stalls, the output register holds and the step counter waits. Reset
// (synchronous, active low) idles the sequencer, empties the output
// register and restores the command registers to 0x28, 0x0F and 0x06.
`default_nettype none
module char_lcd_4bit_interface_sequencer
    import clcd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    clcd_req_if.sink   i_req,
    clcd_cfg_if.sink   i_cfg,
    clcd_upd_if.source o_upd
);

    t_ucw  uw;
    t_disp disp;
    logic  step;
    logic  slot;
    logic  req_ready;

    assign i_req.ready = req_ready;
    assign i_cfg.ready = 1'b1;

    clcd_useq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_disp      (disp),
        .i_slot      (slot),
        .o_uw        (uw),
        .o_step      (step),
        .o_req_ready (req_ready)
    );

    clcd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_fire   (i_req.valid && req_ready),
        .i_op         (i_req.op),
        .i_value_byte (i_req.value_byte),
        .i_column     (i_req.column),
        .i_row        (i_req.row),
        .i_cfg_fire   (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_uw         (uw),
        .i_step       (step),
        .o_disp       (disp),
        .o_slot       (slot),
        .o_upd        (o_upd)
    );

endmodule
`default_nettype wire

// File: rtl/clcd_chk.sv
// Checker: port-level properties of the pin update stream, bound to the top level.
`default_nettype none
module clcd_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic       i_en,
    input wire logic       i_settle,
    input wire logic [5:0] i_wait,
    input wire logic       i_last,
    input wire logic [3:0] i_nib
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("update dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_nib) && $stable(i_en) && $stable(i_last))
        else $error("stalled update changed");

    a_strobe_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_en |-> i_settle && !i_last)
        else $error("enable high without settle or on final update");

    a_wait_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_wait != 6'd0) |-> !i_en)
        else $error("wait issued with enable high");

endmodule

bind char_lcd_4bit_interface_sequencer clcd_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_upd.valid),
    .i_ready  (o_upd.ready),
    .i_en     (o_upd.enable_level),
    .i_settle (o_upd.settle_short),
    .i_wait   (o_upd.wait_ms),
    .i_last   (o_upd.last),
    .i_nib    (o_upd.bus_nibble)
);
`default_nettype wire
